[sv/nvme_queue_command_tracker_macros.svh]
// assertion macros for the nvme queue command tracker
// used by nqct_slot_table and nvme_queue_command_tracker, expects clk_i and rst_ni in scope
`ifndef NVME_QUEUE_COMMAND_TRACKER_MACROS_SVH
`define NVME_QUEUE_COMMAND_TRACKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// plain property checked every cycle out of reset
`define NQCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define NQCT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NQCT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define NQCT_ASSERT(lbl, prop, msg)
`define NQCT_IMPL(lbl, ante, cons, msg)
`define NQCT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/nqct_pkg.sv]
// shared types, constants and helpers of the nvme queue command tracker
// no dependencies; used by the interfaces and all modules
package nqct_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned SLOT_COUNT  = 64;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned OFS_W       = 19;
  localparam int unsigned EXP_W       = 4;
  localparam int unsigned VAL_W       = 6;

  localparam logic [OFS_W-1:0] DOORBELL_BASE = 19'h01000;

  // slot status codes
  localparam logic [1:0] SLOT_FREE      = 2'd0;
  localparam logic [1:0] SLOT_IN_FLIGHT = 2'd1;
  localparam logic [1:0] SLOT_COMPLETED = 2'd2;

  // doorbell register indexes
  localparam logic [1:0] DB_ADMIN_SQ = 2'd0;
  localparam logic [1:0] DB_ADMIN_CQ = 2'd1;

  typedef enum logic [2:0] {
    ACT_ALLOC    = 3'd0,
    ACT_COMPLETE = 3'd1,
    ACT_RELEASE  = 3'd2,
    ACT_QUERY    = 3'd3,
    ACT_SUBMIT   = 3'd4
  } action_e;

  // slot table control and status
  typedef struct packed {
    logic              alloc;
    logic              complete;
    logic              release_slot;
    logic [SLOT_W-1:0] idx;
  } slot_op_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] free_idx;
    logic [1:0]        state;
  } slot_info_t;

  // queue pointer control and status
  typedef struct packed {
    logic             q;
    logic             phase;
    logic             cpl_en;
    logic             sub_en;
    logic [PTR_W-1:0] sq_head;
  } queue_op_t;

  typedef struct packed {
    logic             entry_new;
    logic [PTR_W-1:0] cq_head_next;
    logic             sq_full;
    logic [PTR_W-1:0] sq_tail_next;
  } queue_info_t;

  // one result item
  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic              no_free_slot;
    logic              entry_consumed;
    logic              bad_cmd_tag;
    logic [1:0]        slot_state;
    logic              queue_full;
    logic              doorbell_write;
    logic [OFS_W-1:0]  doorbell_offset;
    logic [VAL_W-1:0]  doorbell_value;
  } rsp_t;

  // base plus index times (4 << exponent), wrapped to the offset width
  function automatic logic [OFS_W-1:0] doorbell_at(input logic [1:0] index,
                                                   input logic [EXP_W-1:0] stride_exp);
    logic [OFS_W-1:0] step;
    step = {{(OFS_W-2){1'b0}}, index} << ({1'b0, stride_exp} + 5'd2);
    return DOORBELL_BASE + step;
  endfunction

endpackage

[sv/nqct_if.sv]
// request, response and configuration channel interfaces
// depends on nqct_pkg for field widths
interface nqct_req_if;
  import nqct_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic              queue_select;
  logic              entry_phase;
  logic [ID_W-1:0]   cmd_tag;
  logic [PTR_W-1:0]  entry_sq_head;

  modport source (output valid, action, queue_select, entry_phase, cmd_tag,
                  entry_sq_head, input ready);
  modport sink   (input valid, action, queue_select, entry_phase, cmd_tag,
                  entry_sq_head, output ready);
endinterface

interface nqct_rsp_if;
  import nqct_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] granted_slot;
  logic              no_free_slot;
  logic              entry_consumed;
  logic              bad_cmd_tag;
  logic [1:0]        slot_state;
  logic              queue_full;
  logic              doorbell_write;
  logic [OFS_W-1:0]  doorbell_offset;
  logic [VAL_W-1:0]  doorbell_value;

  modport source (output valid, granted_slot, no_free_slot, entry_consumed,
                  bad_cmd_tag, slot_state, queue_full, doorbell_write,
                  doorbell_offset, doorbell_value, input ready);
  modport sink   (input valid, granted_slot, no_free_slot, entry_consumed,
                  bad_cmd_tag, slot_state, queue_full, doorbell_write,
                  doorbell_offset, doorbell_value, output ready);
endinterface

interface nqct_cfg_if;
  import nqct_pkg::*;

  logic             valid;
  logic             ready;
  logic [EXP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[sv/nqct_slot_table.sv]
// command slot status bits with lowest-free-slot priority encoder
// depends on nqct_pkg and the assertion macro header
`include "nvme_queue_command_tracker_macros.svh"

module nqct_slot_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nqct_pkg::slot_op_t   op_i,
  output nqct_pkg::slot_info_t info_o
);
  import nqct_pkg::*;

  // busy set = in flight, done set = completed, both clear = free
  logic [SLOT_COUNT-1:0] busy_q, busy_d;
  logic [SLOT_COUNT-1:0] done_q, done_d;
  logic [SLOT_COUNT-1:0] free_vec;

  assign free_vec = ~(busy_q | done_q);

  // lowest free slot
  always_comb begin
    info_o.found    = |free_vec;
    info_o.free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        info_o.free_idx = SLOT_W'(i);
      end
    end
  end

  // status of the addressed slot
  always_comb begin
    if (done_q[op_i.idx]) begin
      info_o.state = SLOT_COMPLETED;
    end else if (busy_q[op_i.idx]) begin
      info_o.state = SLOT_IN_FLIGHT;
    end else begin
      info_o.state = SLOT_FREE;
    end
  end

  // slot updates
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    if (op_i.alloc && info_o.found) begin
      busy_d[info_o.free_idx] = 1'b1;
      done_d[info_o.free_idx] = 1'b0;
    end
    if (op_i.complete) begin
      busy_d[op_i.idx] = 1'b0;
      done_d[op_i.idx] = 1'b1;
    end
    if (op_i.release_slot) begin
      busy_d[op_i.idx] = 1'b0;
      done_d[op_i.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      done_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  `NQCT_ASSERT(a_no_dual_state, !(|(busy_q & done_q)), "slot both in flight and completed")
  `NQCT_IMPL(a_found_is_free, info_o.found, !busy_q[info_o.free_idx] && !done_q[info_o.free_idx], "encoder picked a busy slot")
  `NQCT_NEXT(a_alloc_marks, op_i.alloc && info_o.found, busy_q[$past(info_o.free_idx)], "allocated slot not marked in flight")

endmodule

[sv/nqct_queue_ptrs.sv]
// head, tail and phase registers of the admin and i/o queue pairs
// depends on nqct_pkg
module nqct_queue_ptrs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nqct_pkg::queue_op_t   op_i,
  output nqct_pkg::queue_info_t info_o
);
  import nqct_pkg::*;

  logic [PTR_W-1:0] cq_head_q [2];
  logic [1:0]       cq_phase_q;
  logic [PTR_W-1:0] sq_head_q [2];
  logic [PTR_W-1:0] sq_tail_q [2];
  logic             cq_wrap;

  // completion side: new entry when phase differs, wrap at the last entry
  assign info_o.entry_new    = op_i.phase != cq_phase_q[op_i.q];
  assign cq_wrap             = cq_head_q[op_i.q] == PTR_W'(QUEUE_DEPTH - 1);
  assign info_o.cq_head_next = cq_wrap ? '0 : cq_head_q[op_i.q] + 1'b1;

  // submission side: full when tail plus one meets the head
  assign info_o.sq_tail_next = (sq_tail_q[op_i.q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                             : sq_tail_q[op_i.q] + 1'b1;
  assign info_o.sq_full      = info_o.sq_tail_next == sq_head_q[op_i.q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cq_head_q  <= '{default: '0};
      cq_phase_q <= '0;
      sq_head_q  <= '{default: '0};
      sq_tail_q  <= '{default: '0};
    end else begin
      if (op_i.cpl_en && info_o.entry_new) begin
        cq_head_q[op_i.q] <= info_o.cq_head_next;
        sq_head_q[op_i.q] <= op_i.sq_head;
        if (cq_wrap) begin
          cq_phase_q[op_i.q] <= ~cq_phase_q[op_i.q];
        end
      end
      if (op_i.sub_en && !info_o.sq_full) begin
        sq_tail_q[op_i.q] <= info_o.sq_tail_next;
      end
    end
  end

endmodule

[sv/nvme_queue_command_tracker.sv]
// top level of the nvme queue command tracker: input register, event decode, result register
// depends on nqct_pkg, nqct_if, nqct_slot_table, nqct_queue_ptrs and the macro header
//
// Usage
//   req_i carries one event per request: allocate, completion entry, release, query or
//   submit, with queue select, phase tag, command id and reported submission head.
//   rsp_o returns exactly one result request per event, in order.
//   cfg_i writes the doorbell stride exponent; it is always ready, and the user must write
//   it only while no event is in progress: the block itself does not enforce this.
// Pipeline and throughput
//   an accepted event is held in the input register and evaluated against the slot
//   bits and queue pointers; its result enters the result register when that is empty
//   or being read (two-register path). One event per cycle is sustained unless rsp_o
//   is held off; the limit is the 64-bit slot read-modify-write and its priority encoder.
// Reset
//   rst_ni clears every slot to free, all heads, tails and phases to zero and the
//   stride exponent to zero; both registers come up empty.
// Stall
//   while rsp_o is held off the result stays in its register, one more event waits in
//   the input register and req_i.ready drops until the result is taken.
`include "nvme_queue_command_tracker_macros.svh"

module nvme_queue_command_tracker (
  input  logic             clk_i,
  input  logic             rst_ni,
  nqct_req_if.sink         req_i,
  nqct_rsp_if.source       rsp_o,
  nqct_cfg_if.sink         cfg_i
);
  import nqct_pkg::*;

  // input register
  logic              in_valid_q;
  logic [2:0]        action_q;
  logic              queue_sel_q;
  logic              phase_q;
  logic [ID_W-1:0]   cmd_id_q;
  logic [PTR_W-1:0]  sq_head_q;

  logic              rsp_valid_q, rsp_valid_d;
  rsp_t              rsp_q, rsp_d;
  logic [EXP_W-1:0]  stride_exp_q;

  logic              advance;
  logic              go;
  logic              id_ok;
  slot_op_t          slot_op;
  slot_info_t        slot_info;
  queue_op_t         queue_op;
  queue_info_t       queue_info;

  assign advance     = !rsp_valid_q || rsp_o.ready;
  assign go          = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;
  assign id_ok       = cmd_id_q < ID_W'(SLOT_COUNT);

  // queue pointer control
  always_comb begin
    queue_op         = '0;
    queue_op.q       = queue_sel_q;
    queue_op.phase   = phase_q;
    queue_op.sq_head = sq_head_q;
    if (go) begin
      case (action_q)
        ACT_COMPLETE: queue_op.cpl_en = 1'b1;
        ACT_SUBMIT:   queue_op.sub_en = 1'b1;
        default: ;
      endcase
    end
  end

  // slot table control
  always_comb begin
    slot_op     = '0;
    slot_op.idx = cmd_id_q[SLOT_W-1:0];
    if (go) begin
      case (action_q)
        ACT_ALLOC:   slot_op.alloc        = 1'b1;
        ACT_RELEASE: slot_op.release_slot = id_ok;
        default: ;
      endcase
    end
    slot_op.complete = queue_op.cpl_en && queue_info.entry_new && id_ok;
  end

  nqct_slot_table u_slot_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (slot_op),
    .info_o (slot_info)
  );

  nqct_queue_ptrs u_queue_ptrs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (queue_op),
    .info_o (queue_info)
  );

  // result of the event in the input register
  always_comb begin
    rsp_d = '0;
    case (action_q)
      ACT_ALLOC: begin
        if (slot_info.found) begin
          rsp_d.granted_slot = slot_info.free_idx;
        end else begin
          rsp_d.no_free_slot = 1'b1;
        end
      end
      ACT_COMPLETE: begin
        if (queue_info.entry_new) begin
          rsp_d.bad_cmd_tag     = !id_ok;
          rsp_d.entry_consumed  = 1'b1;
          rsp_d.doorbell_write  = 1'b1;
          rsp_d.doorbell_offset = doorbell_at({queue_sel_q, DB_ADMIN_CQ[0]}, stride_exp_q);
          rsp_d.doorbell_value  = VAL_W'(queue_info.cq_head_next);
        end
      end
      ACT_RELEASE: begin
        rsp_d.bad_cmd_tag = !id_ok;
      end
      ACT_QUERY: begin
        rsp_d.bad_cmd_tag = !id_ok;
        rsp_d.slot_state  = id_ok ? slot_info.state : SLOT_FREE;
      end
      ACT_SUBMIT: begin
        if (queue_info.sq_full) begin
          rsp_d.queue_full = 1'b1;
        end else begin
          rsp_d.doorbell_write  = 1'b1;
          rsp_d.doorbell_offset = doorbell_at({queue_sel_q, DB_ADMIN_SQ[0]}, stride_exp_q);
          rsp_d.doorbell_value  = VAL_W'(queue_info.sq_tail_next);
        end
      end
      default: ;
    endcase
  end

  // result register valid
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (go) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      rsp_valid_q  <= 1'b0;
      stride_exp_q <= '0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (cfg_i.valid) begin
        stride_exp_q <= cfg_i.data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      action_q    <= req_i.action;
      queue_sel_q <= req_i.queue_select;
      phase_q     <= req_i.entry_phase;
      cmd_id_q    <= req_i.cmd_tag;
      sq_head_q   <= req_i.entry_sq_head;
    end
    if (go) begin
      rsp_q <= rsp_d;
    end
  end

  // response port
  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.granted_slot    = rsp_q.granted_slot;
  assign rsp_o.no_free_slot    = rsp_q.no_free_slot;
  assign rsp_o.entry_consumed  = rsp_q.entry_consumed;
  assign rsp_o.bad_cmd_tag     = rsp_q.bad_cmd_tag;
  assign rsp_o.slot_state      = rsp_q.slot_state;
  assign rsp_o.queue_full      = rsp_q.queue_full;
  assign rsp_o.doorbell_write  = rsp_q.doorbell_write;
  assign rsp_o.doorbell_offset = rsp_q.doorbell_offset;
  assign rsp_o.doorbell_value  = rsp_q.doorbell_value;

  `NQCT_IMPL(a_consume_rings, rsp_valid_q && rsp_q.entry_consumed, rsp_q.doorbell_write, "no doorbell")
  `NQCT_IMPL(a_full_silent, rsp_valid_q && rsp_q.queue_full, !rsp_q.doorbell_write, "full rings")
  `NQCT_IMPL(a_stall_blocks, in_valid_q && !advance, !req_i.ready, "input taken while full")

endmodule
